### sv/tps_pkg.sv
// shared types, widths and helpers for the triangle pixel shader
`default_nettype none
package tps_pkg;

	localparam int COORD_W     = 12;
	localparam int DIFF_W      = 13;
	localparam int PROD_W      = 26;
	localparam int CROSS_W     = 27;
	localparam int WIDE_W      = 54;
	localparam int DEN_W       = 51;
	localparam int DIV_W       = 58;
	localparam int CHAN_W      = 8;
	localparam int IDX_W       = 19;
	localparam int IDXF_W      = 23;
	localparam int COLOR_W     = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int DIV_STEPS   = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam int SCREEN_W_DEF = 640;
	localparam int SCREEN_H_DEF = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERT_A_X      = 3'd0,
		REG_VERT_A_Y      = 3'd1,
		REG_VERT_B_X      = 3'd2,
		REG_VERT_B_Y      = 3'd3,
		REG_VERT_C_X      = 3'd4,
		REG_VERT_C_Y      = 3'd5,
		REG_FLAT_COLOR    = 3'd6,
		REG_GRADIENT_MODE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [COLOR_W-1:0]        flat_color;
		logic                      gradient_mode;
	} cfg_t;

	typedef struct packed {
		logic             covered;
		logic             write_enable;
		logic [IDX_W-1:0] pixel_index;
	} meta_t;

	typedef struct packed {
		meta_t                     meta;
		logic signed [CROSS_W-1:0] cr_a;
		logic signed [CROSS_W-1:0] cr_b;
		logic signed [CROSS_W-1:0] cr_k;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		sdiff = DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic logic signed [PROD_W-1:0] smul(input logic signed [DIFF_W-1:0] a,
			input logic signed [DIFF_W-1:0] b);
		smul = PROD_W'(a) * PROD_W'(b);
	endfunction

endpackage
`default_nettype wire

### sv/triangle_pixel_shader.sv
// top level: configuration registers, front and back pipelines joined by a queue
//
//  channel  | handshake              | payload
//  pixel    | pix_valid / pix_stall  | pix_x, pix_y
//  result   | res_valid / res_stall  | covered, write_enable, pixel_index, red, green, blue
//  config   | cfg_we                 | cfg_index, cfg_data
//
// one pixel word per cycle sustained while the queue has room; every stage holds one word
// a result passes through 16 registers after its pixel is accepted: 3 front
// stages, the queue, 2 weight stages, 9 divide stages and the output register
// the divider retires one quotient bit per stage after its entry stage
// reset clears all valid flags, queue pointers and the configuration registers
// a stalled result freezes the back pipeline only; the queue absorbs the front until it is full
`default_nettype none
module triangle_pixel_shader import tps_pkg::*; #(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [COLOR_W-1:0]        cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  logic signed [COORD_W-1:0] pix_x,
	input  logic signed [COORD_W-1:0] pix_y,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      covered,
	output logic                      write_enable,
	output logic [IDX_W-1:0]          pixel_index,
	output logic [CHAN_W-1:0]         red,
	output logic [CHAN_W-1:0]         green,
	output logic [CHAN_W-1:0]         blue
);

	cfg_t   cfg_q;
	logic   push, pop;
	qent_t  push_data, pop_data;
	qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_VERT_A_X:      cfg_q.ax <= cfg_data[COORD_W-1:0];
				REG_VERT_A_Y:      cfg_q.ay <= cfg_data[COORD_W-1:0];
				REG_VERT_B_X:      cfg_q.bx <= cfg_data[COORD_W-1:0];
				REG_VERT_B_Y:      cfg_q.by <= cfg_data[COORD_W-1:0];
				REG_VERT_C_X:      cfg_q.cx <= cfg_data[COORD_W-1:0];
				REG_VERT_C_Y:      cfg_q.cy <= cfg_data[COORD_W-1:0];
				REG_FLAT_COLOR:    cfg_q.flat_color <= cfg_data;
				REG_GRADIENT_MODE: cfg_q.gradient_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tps_front #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_x     (pix_x),
		.pix_y     (pix_y),
		.push      (push),
		.push_data (push_data),
		.qstat     (qstat)
	);

	tps_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	tps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.qstat        (qstat),
		.pop_data     (pop_data),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.covered      (covered),
		.write_enable (write_enable),
		.pixel_index  (pixel_index),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	a_we_needs_cover: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && write_enable |-> covered)
		else $error("write enable on an uncovered pixel");

	a_uncovered_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !covered |-> red == '0 && green == '0 && blue == '0)
		else $error("uncovered pixel carries colour");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue both full and empty");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> qstat.full)
		else $error("pixel input stalled with room in the queue");

endmodule
`default_nettype wire

### sv/tps_front.sv
// front pipeline: edge functions, coverage, screen test and framebuffer index
`default_nettype none
module tps_front import tps_pkg::*; #(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  logic signed [COORD_W-1:0] pix_x,
	input  logic signed [COORD_W-1:0] pix_y,
	output logic                      push,
	output qent_t                     push_data,
	input  qstat_t                    qstat
);

	localparam logic signed [DIFF_W-1:0] W_LIM = DIFF_W'(SCREEN_W);
	localparam logic signed [DIFF_W-1:0] H_LIM = DIFF_W'(SCREEN_H);

	logic en;
	logic v_s1, v_s2, v_s3;

	// triangle edge vectors; the user keeps them constant while words are in flight, the block does not enforce it
	logic signed [DIFF_W-1:0] cb_x, cb_y, ac_x, ac_y, v0_x, v0_y, v1_x, v1_y;
	logic on_scr;

	logic signed [COORD_W-1:0] px_s1, py_s1;
	logic signed [DIFF_W-1:0]  pa_x_s1, pa_y_s1, pb_x_s1, pb_y_s1, pc_x_s1, pc_y_s1;
	logic                      on_s1;

	logic signed [PROD_W-1:0] p1a_s2, p1b_s2, p2a_s2, p2b_s2, p3a_s2, p3b_s2;
	logic signed [PROD_W-1:0] p4a_s2, p4b_s2, p5a_s2, p5b_s2;
	logic                     on_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic [IDXF_W-1:0]        idx_full;

	logic signed [CROSS_W-1:0] e1, e2;
	qent_t ent_s3;

	assign en        = !(v_s3 && qstat.full);
	assign pix_stall = !en;
	assign push      = v_s3 && !qstat.full;
	assign push_data = ent_s3;

	assign cb_x = sdiff(cfg.cx, cfg.bx);
	assign cb_y = sdiff(cfg.cy, cfg.by);
	assign ac_x = sdiff(cfg.ax, cfg.cx);
	assign ac_y = sdiff(cfg.ay, cfg.cy);
	assign v0_x = sdiff(cfg.bx, cfg.ax);
	assign v0_y = sdiff(cfg.by, cfg.ay);
	assign v1_x = sdiff(cfg.cx, cfg.ax);
	assign v1_y = sdiff(cfg.cy, cfg.ay);

	assign on_scr = !pix_x[COORD_W-1] && (DIFF_W'(pix_x) < W_LIM)
		&& !pix_y[COORD_W-1] && (DIFF_W'(pix_y) < H_LIM);

	assign idx_full = IDXF_W'(py_s1[COORD_W-2:0]) * IDXF_W'(SCREEN_W)
		+ IDXF_W'(px_s1[COORD_W-2:0]);

	assign e1 = CROSS_W'(p1a_s2) - CROSS_W'(p1b_s2);
	assign e2 = CROSS_W'(p2a_s2) - CROSS_W'(p2b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= pix_x;
			py_s1   <= pix_y;
			on_s1   <= on_scr;
			pa_x_s1 <= sdiff(pix_x, cfg.ax);
			pa_y_s1 <= sdiff(pix_y, cfg.ay);
			pb_x_s1 <= sdiff(pix_x, cfg.bx);
			pb_y_s1 <= sdiff(pix_y, cfg.by);
			pc_x_s1 <= sdiff(pix_x, cfg.cx);
			pc_y_s1 <= sdiff(pix_y, cfg.cy);

			p1a_s2 <= smul(cb_x, pb_y_s1);
			p1b_s2 <= smul(cb_y, pb_x_s1);
			p2a_s2 <= smul(ac_x, pc_y_s1);
			p2b_s2 <= smul(ac_y, pc_x_s1);
			p3a_s2 <= smul(v0_x, pa_y_s1);
			p3b_s2 <= smul(v0_y, pa_x_s1);
			p4a_s2 <= smul(v1_x, pa_y_s1);
			p4b_s2 <= smul(v1_y, pa_x_s1);
			p5a_s2 <= smul(v0_x, v1_y);
			p5b_s2 <= smul(v0_y, v1_x);
			on_s2  <= on_s1;
			idx_s2 <= on_s1 ? idx_full[IDX_W-1:0] : '0;

			ent_s3.cr_b <= CROSS_W'(p3a_s2) - CROSS_W'(p3b_s2);
			ent_s3.cr_a <= CROSS_W'(p4a_s2) - CROSS_W'(p4b_s2);
			ent_s3.cr_k <= CROSS_W'(p5a_s2) - CROSS_W'(p5b_s2);
			ent_s3.meta.covered <= !e1[CROSS_W-1] && !e2[CROSS_W-1]
				&& (p3a_s2 >= p3b_s2);
			ent_s3.meta.write_enable <= on_s2 && !e1[CROSS_W-1] && !e2[CROSS_W-1]
				&& (p3a_s2 >= p3b_s2);
			ent_s3.meta.pixel_index <= idx_s2;
		end
	end

endmodule
`default_nettype wire

### sv/tps_queue.sv
// short word queue between the front and back pipelines
`default_nettype none
module tps_queue import tps_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  push_data,
	input  logic   pop,
	output qent_t  pop_data,
	output qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t ent_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_data    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### sv/tps_back.sv
// back pipeline: barycentric weights, pipelined divide, colour select, output register
`default_nettype none
module tps_back import tps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  qstat_t            qstat,
	input  qent_t             pop_data,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              covered,
	output logic              write_enable,
	output logic [IDX_W-1:0]  pixel_index,
	output logic [CHAN_W-1:0] red,
	output logic [CHAN_W-1:0] green,
	output logic [CHAN_W-1:0] blue
);

	localparam int NST = DIV_STEPS + 1;

	logic ben;

	logic                     v_s1;
	meta_t                    m_s1;
	logic signed [WIDE_W-1:0] ak_s1, bk_s1, kk_s1;

	logic                     v_s2;
	meta_t                    m_s2;
	logic signed [WIDE_W-1:0] den_s2;
	logic signed [WIDE_W-1:0] num_s2 [3];

	// index k holds stage 3 + k: entry prep, then one quotient bit per stage
	logic                    v_s3   [NST];
	meta_t                   m_s3   [NST];
	logic [DEN_W-1:0]        den_s3 [NST];
	logic [DIV_W-1:0]        rem_s3 [NST][3];
	logic [CHAN_W-1:0]       quo_s3 [NST][3];
	logic [2:0]              zero_s3 [NST];
	logic [2:0]              sat_s3  [NST];

	logic              res_valid_q, covered_q, write_enable_q;
	logic [IDX_W-1:0]  pixel_index_q;
	logic [CHAN_W-1:0] red_q, green_q, blue_q;
	logic [CHAN_W-1:0] grad [3];

	assign ben = !res_valid_q || !res_stall;
	assign pop = ben && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (ben) begin
			v_s1        <= !qstat.empty;
			v_s2        <= v_s1;
			res_valid_q <= v_s3[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			m_s1  <= pop_data.meta;
			ak_s1 <= WIDE_W'(pop_data.cr_a) * WIDE_W'(pop_data.cr_k);
			bk_s1 <= WIDE_W'(pop_data.cr_b) * WIDE_W'(pop_data.cr_k);
			kk_s1 <= WIDE_W'(pop_data.cr_k) * WIDE_W'(pop_data.cr_k);

			// weights of a, b and c over the squared double area
			m_s2      <= m_s1;
			den_s2    <= kk_s1;
			num_s2[0] <= kk_s1 + ak_s1 - bk_s1;
			num_s2[1] <= -ak_s1;
			num_s2[2] <= bk_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3[0] <= 1'b0;
		end else if (ben) begin
			v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			m_s3[0]   <= m_s2;
			den_s3[0] <= den_s2[DEN_W-1:0];
			for (int c = 0; c < 3; c++) begin
				zero_s3[0][c] <= num_s2[c][WIDE_W-1] || (den_s2 == '0);
				sat_s3[0][c]  <= !num_s2[c][WIDE_W-1] && (den_s2 != '0)
					&& (num_s2[c] >= den_s2);
				rem_s3[0][c]  <= (DIV_W'($unsigned(num_s2[c])) << CHAN_W)
					- DIV_W'($unsigned(num_s2[c]));
				quo_s3[0][c]  <= '0;
			end
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int BITP = DIV_STEPS - 1 - j;
		logic [DIV_W-1:0] trial;

		assign trial = DIV_W'(den_s3[j]) << BITP;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[j+1] <= 1'b0;
			end else if (ben) begin
				v_s3[j+1] <= v_s3[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ben) begin
				m_s3[j+1]    <= m_s3[j];
				den_s3[j+1]  <= den_s3[j];
				zero_s3[j+1] <= zero_s3[j];
				sat_s3[j+1]  <= sat_s3[j];
				for (int c = 0; c < 3; c++) begin
					if (rem_s3[j][c] >= trial) begin
						rem_s3[j+1][c] <= rem_s3[j][c] - trial;
						quo_s3[j+1][c] <= quo_s3[j][c] | CHAN_W'(1 << BITP);
					end else begin
						rem_s3[j+1][c] <= rem_s3[j][c];
						quo_s3[j+1][c] <= quo_s3[j][c];
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (zero_s3[NST-1][c]) begin
				grad[c] = '0;
			end else if (sat_s3[NST-1][c]) begin
				grad[c] = '1;
			end else begin
				grad[c] = quo_s3[NST-1][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			covered_q      <= m_s3[NST-1].covered;
			write_enable_q <= m_s3[NST-1].write_enable;
			pixel_index_q  <= m_s3[NST-1].pixel_index;
			if (!m_s3[NST-1].covered) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end else if (cfg.gradient_mode) begin
				red_q   <= grad[0];
				green_q <= grad[1];
				blue_q  <= grad[2];
			end else begin
				red_q   <= cfg.flat_color[23:16];
				green_q <= cfg.flat_color[15:8];
				blue_q  <= cfg.flat_color[7:0];
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign covered      = covered_q;
	assign write_enable = write_enable_q;
	assign pixel_index  = pixel_index_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;

endmodule
`default_nettype wire
